// File: hdl/lpoq_pkg.sv
// Shared types, codes and constants of the LRU page order queue.
package lpoq_pkg;

  localparam int unsigned LPOQ_DEPTH     = 16;
  localparam int unsigned LPOQ_PAGE_BITS = 16;

  localparam int unsigned PAGE_W      = 16;
  localparam int unsigned COUNT_OUT_W = 5;

  localparam logic [1:0] REQ_TOUCH   = 2'd0;
  localparam logic [1:0] REQ_APPEND  = 2'd1;
  localparam logic [1:0] REQ_DEQUEUE = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [PAGE_W-1:0] page_in;
  } lpoq_req_t;

  typedef struct packed {
    logic                   ok;
    logic [PAGE_W-1:0]      page_out;
    logic                   was_present;
    logic [COUNT_OUT_W-1:0] count_after;
  } lpoq_rsp_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_MOVE,
    OP_PUSH,
    OP_POP
  } lpoq_op_e;

  typedef struct packed {
    logic     capture;
    lpoq_op_e op;
    logic     load_out;
    logic     ok;
    logic     present;
  } lpoq_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       empty;
    logic       full;
    logic       any_match;
    logic       newest_match;
  } lpoq_stat_t;

endpackage

// File: hdl/lpoq_datapath.sv
// Datapath of the LRU page order queue: ordered page store, count, match vector, result register.
module lpoq_datapath import lpoq_pkg::*; #(
  parameter int unsigned DEPTH     = LPOQ_DEPTH,
  parameter int unsigned PAGE_BITS = LPOQ_PAGE_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lpoq_cmd_t  cmd_i,
  input  lpoq_req_t  req_i,
  output lpoq_stat_t stat_o,
  output lpoq_rsp_t  rsp_o
);

  localparam int unsigned SW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [SW-1:0]    store_q [DEPTH];
  logic [SW-1:0]    store_d [DEPTH];
  logic [CW-1:0]    count_q, count_d;
  logic [SW-1:0]    page_q;
  logic [1:0]       req_q;
  logic [DEPTH-1:0] match_q, match_d;
  logic             newest_q, newest_d;
  logic [DEPTH-1:0] prefix;
  lpoq_rsp_t        rsp_q, rsp_d;
  logic [SW-1:0]    page_m;

  assign page_m = SW'(req_i.page_in);

  // Parallel compare against the held entries, done as the transaction is taken.
  always_comb begin
    match_d  = '0;
    newest_d = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i] = (CW'(i) < count_q) && (store_q[i] == page_m);
      if (match_d[i] && (CW'(i + 1) == count_q)) begin
        newest_d = 1'b1;
      end
    end
  end

  // Marks every entry at or above the oldest match.
  always_comb begin
    prefix[0] = match_q[0];
    for (int i = 1; i < DEPTH; i++) begin
      prefix[i] = prefix[i-1] | match_q[i];
    end
  end

  always_comb begin
    count_d = count_q;
    for (int i = 0; i < DEPTH; i++) begin
      store_d[i] = store_q[i];
    end
    case (cmd_i.op)
      OP_MOVE: begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          if (prefix[i] && (CW'(i + 1) < count_q)) begin
            store_d[i] = store_q[i+1];
          end
        end
        for (int i = 0; i < DEPTH; i++) begin
          if (CW'(i + 1) == count_q) begin
            store_d[i] = page_q;
          end
        end
      end
      OP_PUSH: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (CW'(i) == count_q) begin
            store_d[i] = page_q;
          end
        end
        count_d = count_q + CW'(1);
      end
      OP_POP: begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          store_d[i] = store_q[i+1];
        end
        count_d = count_q - CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp_d             = rsp_q;
    rsp_d.ok          = cmd_i.ok;
    rsp_d.was_present = cmd_i.present;
    rsp_d.page_out    = (cmd_i.op == OP_POP) ? PAGE_W'(store_q[0]) : '0;
    rsp_d.count_after = COUNT_OUT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      store_q[i] <= store_d[i];
    end
    if (cmd_i.capture) begin
      page_q   <= page_m;
      req_q    <= req_i.req_type;
      match_q  <= match_d;
      newest_q <= newest_d;
    end
    if (cmd_i.load_out) begin
      rsp_q <= rsp_d;
    end
  end

  assign stat_o.req_type     = req_q;
  assign stat_o.empty        = (count_q == '0);
  assign stat_o.full         = (count_q >= CW'(DEPTH));
  assign stat_o.any_match    = |match_q;
  assign stat_o.newest_match = newest_q;
  assign rsp_o               = rsp_q;

endmodule

// File: hdl/lpoq_ctrl.sv
// Controller of the LRU page order queue: sequences each transaction and owns the output valid.
module lpoq_ctrl import lpoq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  lpoq_stat_t stat_i,
  output lpoq_cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.op      = OP_NONE;
    cmd_o.capture = in_valid_i && (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
          case (stat_i.req_type)
            REQ_TOUCH: begin
              // A touch of the newest page leaves the order as it is.
              if (stat_i.newest_match) begin
                cmd_o.ok      = 1'b1;
                cmd_o.present = 1'b1;
              end else if (stat_i.any_match) begin
                cmd_o.op      = OP_MOVE;
                cmd_o.ok      = 1'b1;
                cmd_o.present = 1'b1;
              end else if (!stat_i.full) begin
                cmd_o.op = OP_PUSH;
                cmd_o.ok = 1'b1;
              end
            end
            REQ_APPEND: begin
              if (!stat_i.full) begin
                cmd_o.op = OP_PUSH;
                cmd_o.ok = 1'b1;
              end
            end
            REQ_DEQUEUE: begin
              if (!stat_i.empty) begin
                cmd_o.op = OP_POP;
                cmd_o.ok = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/lru_page_order_queue.sv
// Top level of the LRU page order queue.
// Holds up to DEPTH page numbers in least-recently-used order, oldest at the front.
// Input channel (in_valid_i/in_ready_o, in_data_i) carries one request per transaction:
// touch moves a held page to the back or appends it, append adds at the back without
// searching, dequeue removes and returns the oldest page.
// Output channel (out_valid_o/out_ready_i, out_data_o) returns one result per request.
// A request is worked in steps: the first registers a parallel compare of
// the page against every held entry, the second shifts the store and loads the result.
// The controller works on one request at a time, so in_ready_o is low during the second step.
// If the receiver stalls, the result stays in the output register and the next request is
// taken but waits in its second step until the register is freed.
// Reset empties the queue and clears the output valid; the store itself is not cleared,
// since entries at or above the count never affect a result.
module lru_page_order_queue import lpoq_pkg::*; #(
  parameter int unsigned DEPTH     = LPOQ_DEPTH,
  parameter int unsigned PAGE_BITS = LPOQ_PAGE_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lpoq_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lpoq_rsp_t out_data_o
);

  lpoq_cmd_t  cmd;
  lpoq_stat_t stat;

  lpoq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lpoq_datapath #(
    .DEPTH     (DEPTH),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_data_i),
    .stat_o (stat),
    .rsp_o  (out_data_o)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the LRU page order queue: directed and random requests.
module testbench;
  import lpoq_pkg::*;

  localparam logic [1:0]        REQ_RESERVED = 2'd3;
  localparam logic [PAGE_W-1:0] PAGE_MASK    = {PAGE_W{1'b1}} >> (PAGE_W - LPOQ_PAGE_BITS);
  localparam int                RAND_ITEMS   = 1000;
  localparam int                CYCLE_LIMIT  = 200000;
  localparam int                DRAIN_CYCLES = 16;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  lpoq_req_t in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  lpoq_rsp_t out_data_o;

  lpoq_req_t pending_q[$];
  lpoq_rsp_t expected_q[$];

  // Shadow copy of the page order, oldest entry at index zero.
  logic [PAGE_W-1:0] page_store [LPOQ_DEPTH];
  int                held_cnt = 0;

  int cycle_cnt     = 0;
  int err_cnt       = 0;
  int reqs_offered  = 0;
  int reqs_accepted = 0;
  int burst_left    = 1;
  int gap_left      = 0;
  int stall_left    = 0;
  logic [15:0] ready_pat = '1;

  lru_page_order_queue u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < held_cnt; i++) begin
      page_store[i] = page_store[i + 1];
    end
    held_cnt--;
  endfunction

  function automatic lpoq_rsp_t lru_apply(lpoq_req_t req);
    lpoq_rsp_t         rsp;
    logic [PAGE_W-1:0] pg;
    int                hit;
    rsp = '0;
    pg  = req.page_in & PAGE_MASK;
    hit = -1;
    case (req.req_type)
      REQ_TOUCH: begin
        if (held_cnt > 0 && page_store[held_cnt - 1] == pg) begin
          rsp.ok          = 1'b1;
          rsp.was_present = 1'b1;
        end else begin
          for (int i = 0; i < held_cnt; i++) begin
            if (hit < 0 && page_store[i] == pg) hit = i;
          end
          if (hit >= 0) begin
            // The oldest copy moves to the back; the store cannot overflow here.
            drop_entry(hit);
            page_store[held_cnt] = pg;
            held_cnt++;
            rsp.ok          = 1'b1;
            rsp.was_present = 1'b1;
          end else if (held_cnt < LPOQ_DEPTH) begin
            page_store[held_cnt] = pg;
            held_cnt++;
            rsp.ok = 1'b1;
          end
        end
      end
      REQ_APPEND: begin
        if (held_cnt < LPOQ_DEPTH) begin
          page_store[held_cnt] = pg;
          held_cnt++;
          rsp.ok = 1'b1;
        end
      end
      REQ_DEQUEUE: begin
        if (held_cnt > 0) begin
          rsp.page_out = page_store[0];
          drop_entry(0);
          rsp.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rsp.count_after = held_cnt[COUNT_OUT_W-1:0];
    return rsp;
  endfunction

  task automatic queue_req(logic [1:0] req_type, logic [PAGE_W-1:0] page);
    lpoq_req_t req;
    req.req_type = req_type;
    req.page_in  = page;
    pending_q.push_back(req);
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin : driver
    logic      nxt_valid;
    lpoq_req_t nxt_data;
    nxt_valid = in_valid_i;
    nxt_data  = in_data_i;
    if (rst_ni) begin
      if (in_valid_i && reqs_accepted == reqs_offered) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() != 0) begin
          nxt_data  = pending_q.pop_front();
          nxt_valid = 1'b1;
          reqs_offered++;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
    in_valid_i <= nxt_valid;
    in_data_i  <= nxt_data;
  end

  // Result receiver: ready follows a rotating pattern that is redrawn now and then.
  always @(negedge clk_i) begin : receiver
    if (stall_left == 0) begin
      stall_left = $urandom_range(16, 160);
      case ($urandom_range(0, 3))
        0: ready_pat = '1;
        1: ready_pat = 16'($urandom);
        2: ready_pat = 16'($urandom | $urandom);
        default: ready_pat = 16'($urandom & $urandom);
      endcase
      if (ready_pat == '0) ready_pat = 16'h0001;
    end
    stall_left--;
    ready_pat = {ready_pat[0], ready_pat[15:1]};
    out_ready_i <= ready_pat[0];
  end

  always @(posedge clk_i) begin : monitor
    lpoq_rsp_t exp_rsp;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing expected: ok=%0d page_out=%h present=%0d count=%0d",
                   $time, out_data_o.ok, out_data_o.page_out, out_data_o.was_present,
                   out_data_o.count_after);
        end else begin
          exp_rsp = expected_q.pop_front();
          if (out_data_o !== exp_rsp) begin
            err_cnt++;
            $display("%0t: expected ok=%0d page_out=%h present=%0d count=%0d", $time,
                     exp_rsp.ok, exp_rsp.page_out, exp_rsp.was_present,
                     exp_rsp.count_after);
            $display("%0t:      got ok=%0d page_out=%h present=%0d count=%0d", $time,
                     out_data_o.ok, out_data_o.page_out, out_data_o.was_present,
                     out_data_o.count_after);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_q.push_back(lru_apply(in_data_i));
        reqs_accepted <= reqs_accepted + 1;
      end
    end
  end

  initial begin : stimulus
    logic [PAGE_W-1:0] pool [8];
    logic [PAGE_W-1:0] pg;
    logic [1:0]        rt;
    int                n_rand;
    int                seg_len;
    int                roll;
    int                touch_lim;
    int                append_lim;
    int                dequeue_lim;

    // Empty dequeue, newest-page touch, duplicates and the oldest copy moving.
    queue_req(REQ_DEQUEUE,  16'h0000);
    queue_req(REQ_TOUCH,    16'h0000);
    queue_req(REQ_TOUCH,    16'h0000);
    queue_req(REQ_APPEND,   16'hFFFF);
    queue_req(REQ_APPEND,   16'h0000);
    queue_req(REQ_TOUCH,    16'h0000);
    queue_req(REQ_APPEND,   16'h1234);
    queue_req(REQ_TOUCH,    16'h0000);
    queue_req(REQ_RESERVED, 16'hA5A5);
    // Fill the store, then try to grow it past full.
    for (int i = 0; i < 12; i++) queue_req(REQ_APPEND, 16'h0001 << i);
    queue_req(REQ_APPEND,   16'h5555);
    queue_req(REQ_TOUCH,    16'hAAAA);
    queue_req(REQ_TOUCH,    16'hFFFF);
    queue_req(REQ_DEQUEUE,  16'hFFFF);

    // Random segments that lean towards filling, draining or a mix, over a small
    // pool of pages so that touches often hit.
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      seg_len = $urandom_range(4, 40);
      case ($urandom_range(0, 2))
        0: begin touch_lim = 45; append_lim = 90; dequeue_lim = 98; end
        1: begin touch_lim = 20; append_lim = 30; dequeue_lim = 98; end
        default: begin touch_lim = 45; append_lim = 65; dequeue_lim = 98; end
      endcase
      for (int k = 0; k < 8; k++) begin
        pool[k] = ($urandom_range(0, 3) == 0) ? PAGE_W'($urandom_range(0, 65535))
                                               : PAGE_W'($urandom_range(0, 11));
      end
      pool[7] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      for (int j = 0; j < seg_len; j++) begin
        roll = $urandom_range(0, 99);
        if (roll < touch_lim)        rt = REQ_TOUCH;
        else if (roll < append_lim)  rt = REQ_APPEND;
        else if (roll < dequeue_lim) rt = REQ_DEQUEUE;
        else                         rt = REQ_RESERVED;
        pg = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 7)]
                                        : PAGE_W'($urandom_range(0, 65535));
        queue_req(rt, pg);
        if (rt != REQ_RESERVED) n_rand++;
      end
    end

    while ((pending_q.size() != 0 || in_valid_i || expected_q.size() != 0)
           && cycle_cnt < CYCLE_LIMIT) begin
      @(negedge clk_i);
    end
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk_i);
      if (err_cnt == 0 && expected_q.size() == 0) begin
        $display("testbench OK");
      end else begin
        $display("testbench NOT OK");
      end
    end
    $finish;
  end

endmodule
